// File: rtl/tss_pkg.sv
// Shared types and constants for the tone step sequencer.
// Field widths, beat layouts and action codes used by the top level and the checker.
// Depends on nothing.
package tss_pkg;

  // Widths of the beat fields.
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 4;
  localparam int FREQ_W   = 16;
  localparam int DUR_W    = 16;
  localparam int LEN_W    = 5;

  // Bus widths; the tdata widths are padded to whole bytes.
  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;

  // Bit positions of the fields within the input tdata.
  localparam int IDX_LSB  = 0;
  localparam int FREQ_LSB = IDX_LSB + INDEX_W;
  localparam int DUR_LSB  = FREQ_LSB + FREQ_W;
  localparam int LEN_LSB  = DUR_LSB + DUR_W;

  // Bit positions of the fields within the output tdata.
  localparam int SOUND_BIT = FREQ_W;
  localparam int BUSY_BIT  = FREQ_W + 1;
  localparam int OUT_PAD_W = M_TDATA_W - FREQ_W - 2;

  // Kind of an input beat, carried on tuser.
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_STOP  = 2'd3
  } action_t;

  // One entry of the step table.
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } step_entry_t;

  localparam int ENTRY_W = FREQ_W + DUR_W;

endpackage

// File: rtl/tss_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; contents are undefined until written.
// Depends on nothing.
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tone_step_sequencer_unit.sv
// Tone step sequencer: top level, holding the step table RAM and the playback state.
// Depends on tss_pkg and tss_ram.
// Pipeline: an accepted beat passes the stage register, where its table read completes,
// then the output register. Throughput: one beat per cycle while the output is not stalled;
// the table read is issued at acceptance and used as the beat leaves the stage, with the
// step pointer forwarded from the beat ahead of it.
// Reset (rst, synchronous): the sequencer is idle and muted, the pipeline is empty;
// the step table is not cleared and needs no clearing pass.
module tone_step_sequencer_unit #(
  parameter int MAX_STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // step_index[3:0], step_freq[19:4], step_duration[35:20], seq_length[40:36], zeros
  input  logic [tss_pkg::S_TDATA_W-1:0]  s_tdata,
  // action[1:0]
  input  logic [tss_pkg::S_TUSER_W-1:0]  s_tuser,
  // Output stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // tone_freq[15:0], sounding[16], busy_res[17], zeros
  output logic [tss_pkg::M_TDATA_W-1:0]  m_tdata
);

  localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int LW    = tss_pkg::LEN_W;

  // Input field extraction.
  tss_pkg::action_t            in_action;
  logic [tss_pkg::INDEX_W-1:0] in_index;
  logic [tss_pkg::FREQ_W-1:0]  in_freq;
  logic [tss_pkg::DUR_W-1:0]   in_dur;
  logic [LW-1:0]               in_len;

  assign in_action = tss_pkg::action_t'(s_tuser[tss_pkg::ACTION_W-1:0]);
  assign in_index  = s_tdata[tss_pkg::IDX_LSB +: tss_pkg::INDEX_W];
  assign in_freq   = s_tdata[tss_pkg::FREQ_LSB +: tss_pkg::FREQ_W];
  assign in_dur    = s_tdata[tss_pkg::DUR_LSB +: tss_pkg::DUR_W];
  assign in_len    = s_tdata[tss_pkg::LEN_LSB +: LW];

  // Pipeline stage holding an accepted beat while its table read completes.
  logic             s1_valid;
  tss_pkg::action_t s1_action;
  logic [LW-1:0]    s1_len;

  // Playback state.
  logic [LW-1:0]               active_length;
  logic [LW-1:0]               step_pointer;
  logic [tss_pkg::DUR_W-1:0]   time_left;
  logic                        running;
  logic [tss_pkg::FREQ_W-1:0]  current_tone;

  logic [LW-1:0]               active_length_next;
  logic [LW-1:0]               step_pointer_next;
  logic [tss_pkg::DUR_W-1:0]   time_left_next;
  logic                        running_next;
  logic [tss_pkg::FREQ_W-1:0]  current_tone_next;

  logic accept;
  logic advance;

  // Table RAM signals.
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  tss_pkg::step_entry_t    ram_wdata;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  tss_pkg::step_entry_t    ram_rdata;

  // Handshake: the stage moves on when the output register is free or being emptied.
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // Execute the beat in the stage against the entry read for it.
  always_comb begin
    logic [LW-1:0]             len_clamped;
    logic [tss_pkg::DUR_W-1:0] tl_dec;
    logic [LW-1:0]             ptr_inc;

    active_length_next = active_length;
    step_pointer_next  = step_pointer;
    time_left_next     = time_left;
    running_next       = running;
    current_tone_next  = current_tone;

    len_clamped = (32'(s1_len) > MAX_STEPS) ? LW'(MAX_STEPS) : s1_len;
    tl_dec      = (time_left != '0) ? time_left - 1'b1 : '0;
    ptr_inc     = step_pointer + 1'b1;

    if (advance) begin
      unique case (s1_action)
        tss_pkg::ACT_LOAD: begin
          // The table write took place at acceptance.
        end
        tss_pkg::ACT_START: begin
          if (s1_len != '0) begin
            active_length_next = len_clamped;
            step_pointer_next  = '0;
            running_next       = 1'b1;
            current_tone_next  = ram_rdata.freq;
            time_left_next     = ram_rdata.dur;
          end
        end
        tss_pkg::ACT_TICK: begin
          if (running) begin
            time_left_next = tl_dec;
            if (tl_dec == '0) begin
              if (ptr_inc >= active_length) begin
                running_next      = 1'b0;
                current_tone_next = '0;
              end else begin
                step_pointer_next = ptr_inc;
                current_tone_next = ram_rdata.freq;
                time_left_next    = ram_rdata.dur;
              end
            end
          end
        end
        tss_pkg::ACT_STOP: begin
          running_next      = 1'b0;
          current_tone_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Table access at acceptance: loads write, starts read entry 0, ticks read the
  // entry after the pointer as left by the beat ahead.
  always_comb begin
    ram_we         = accept && (in_action == tss_pkg::ACT_LOAD) && (32'(in_index) < MAX_STEPS);
    ram_waddr      = IDX_W'(in_index);
    ram_wdata.freq = in_freq;
    ram_wdata.dur  = in_dur;
    ram_re         = accept && ((in_action == tss_pkg::ACT_START) ||
                                (in_action == tss_pkg::ACT_TICK));
    ram_raddr      = (in_action == tss_pkg::ACT_START) ? '0
                                                       : IDX_W'(LW'(step_pointer_next + 1'b1));
  end

  tss_ram #(
    .WIDTH (tss_pkg::ENTRY_W),
    .DEPTH (MAX_STEPS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_action <= in_action;
      s1_len    <= in_len;
    end
  end

  // Playback state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_length <= '0;
      step_pointer  <= '0;
      time_left     <= '0;
      running       <= 1'b0;
      current_tone  <= '0;
    end else begin
      active_length <= active_length_next;
      step_pointer  <= step_pointer_next;
      time_left     <= time_left_next;
      running       <= running_next;
      current_tone  <= current_tone_next;
    end
  end

  // Output register, loaded as the beat leaves the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= {{tss_pkg::OUT_PAD_W{1'b0}}, running_next,
                  (current_tone_next != '0), current_tone_next};
    end
  end

endmodule

// File: rtl/tss_checker.sv
// Port-level checker for the tone step sequencer, bound to the top level.
// Depends on tss_pkg and on the ports of tone_step_sequencer_unit.
module tss_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tss_pkg::M_TDATA_W-1:0] m_tdata
);

  // No result beat is offered straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat offered after reset");

  // The sounding flag matches a non-zero tone.
  a_sounding: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[tss_pkg::SOUND_BIT] ==
                  (m_tdata[tss_pkg::FREQ_W-1:0] != '0)))
    else $error("sounding flag disagrees with tone frequency");

  // An idle sequencer is always muted.
  a_idle_muted: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[tss_pkg::BUSY_BIT]) |-> (m_tdata[tss_pkg::FREQ_W-1:0] == '0))
    else $error("tone driven while not busy");

  // A stalled result beat holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

  // Input is ready when the output stays empty and no input was offered.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid && $past(!m_tvalid) && !$past(rst) && !$past(s_tvalid)) |-> s_tready)
    else $error("input stalled with an empty pipeline");

endmodule

bind tone_step_sequencer_unit tss_checker u_tss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
